/* hdl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and byte-level helpers shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_STR  = 4'd1,
    PH_ESC  = 4'd2,
    PH_HI0  = 4'd3,
    PH_HI1  = 4'd4,
    PH_HI2  = 4'd5,
    PH_HI3  = 4'd6,
    PH_SBS  = 4'd7,
    PH_SU   = 4'd8,
    PH_LO0  = 4'd9,
    PH_LO1  = 4'd10,
    PH_LO2  = 4'd11,
    PH_LO3  = 4'd12
  } phase_t;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CLOSED = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_CONTROL   = 3'd2;
  localparam logic [2:0] ERR_ESCAPE    = 3'd3;
  localparam logic [2:0] ERR_HEX       = 3'd4;
  localparam logic [2:0] ERR_SURROGATE = 3'd5;
  localparam logic [2:0] ERR_UTF8      = 3'd6;
  localparam logic [2:0] ERR_END       = 3'd7;

  localparam logic [1:0] LIM_NONE = 2'd0;
  localparam logic [1:0] LIM_MIN  = 2'd1;
  localparam logic [1:0] LIM_MAX  = 2'd2;

  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_U      = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [10:0] SUPP_PLANE = 11'd64;

  typedef struct packed {
    logic [1:0] pending;
    logic [1:0] limit;
    logic       bad;
  } utf_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } enc_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic [1:0]      kind;
    logic [2:0]      code;
  } grp_t;

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
      return {1'b0, t[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
      return {1'b0, t[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
      return {1'b0, t[3:0]};
    end
    return 5'h10;
  endfunction

  function automatic logic [8:0] short_escape(logic [7:0] c);
    case (c)
      8'h22:   return {1'b1, 8'h22};
      8'h5C:   return {1'b1, 8'h5C};
      8'h2F:   return {1'b1, 8'h2F};
      8'h62:   return {1'b1, 8'h08};
      8'h66:   return {1'b1, 8'h0C};
      8'h6E:   return {1'b1, 8'h0A};
      8'h72:   return {1'b1, 8'h0D};
      8'h74:   return {1'b1, 8'h09};
      default: return 9'd0;
    endcase
  endfunction

  function automatic enc_t utf8_encode(logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.bytes[0] = cp[7:0];
      e.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
      e.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

  function automatic utf_t utf8_step(utf_t s, logic [7:0] b);
    utf_t       r;
    logic [7:0] bound;
    logic       ok;
    r = s;
    bound = (s.pending == 2'd2) ? 8'hA0 : 8'h90;
    ok = (b[7:6] == 2'b10);
    if (s.pending == 2'd0) begin
      if (b <= 8'h7F) begin
        r = s;
      end else if (b inside {[8'hC2:8'hDF]}) begin
        r.pending = 2'd1;
        r.limit   = LIM_NONE;
      end else if (b inside {[8'hE0:8'hEF]}) begin
        r.pending = 2'd2;
        r.limit   = (b == 8'hE0) ? LIM_MIN : (b == 8'hED) ? LIM_MAX : LIM_NONE;
      end else if (b inside {[8'hF0:8'hF4]}) begin
        r.pending = 2'd3;
        r.limit   = (b == 8'hF0) ? LIM_MIN : (b == 8'hF4) ? LIM_MAX : LIM_NONE;
      end else begin
        r.bad = 1'b1;
      end
    end else begin
      if (s.limit == LIM_MIN && b < bound) ok = 1'b0;
      if (s.limit == LIM_MAX && b >= bound) ok = 1'b0;
      if (!ok) begin
        r.bad     = 1'b1;
        r.pending = 2'd0;
      end else begin
        r.pending = s.pending - 2'd1;
      end
      r.limit = LIM_NONE;
    end
    return r;
  endfunction

endpackage

/* hdl/jsu_decode.sv */
// ----------------------------------------------------------------------------
// jsu_decode
// Decoder state and single-pass decode of one registered input byte into a
// group of up to four results, with the UTF-8 validator.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          in_byte,
  input  logic                line_end,
  input  logic                advance,
  output logic                has_result,
  output jsu_pkg::grp_t       grp
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     acc, acc_next;
  logic [9:0]      hs, hs_next;
  jsu_pkg::utf_t   utf, utf_next;

  logic [4:0]      dig;
  logic [15:0]     acc_shift;
  logic [8:0]      esc;
  logic            err;
  logic [2:0]      err_code;
  logic            closed;
  logic            has_bytes;
  jsu_pkg::enc_t   enc;

  assign dig       = jsu_pkg::hex_value(in_byte);
  assign acc_shift = {acc[11:0], dig[3:0]};
  assign esc       = jsu_pkg::short_escape(in_byte);

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    hs_next    = hs;
    utf_next   = utf;
    err        = 1'b0;
    err_code   = jsu_pkg::ERR_NONE;
    closed     = 1'b0;
    has_bytes  = 1'b0;
    enc        = '0;
    case (phase)
      jsu_pkg::PH_STR: begin
        if (in_byte == jsu_pkg::CHR_QUOTE) begin
          if (utf.bad || utf.pending != 2'd0) begin
            err      = 1'b1;
            err_code = jsu_pkg::ERR_UTF8;
          end else begin
            closed = 1'b1;
          end
        end else if (in_byte < jsu_pkg::CTRL_LIMIT) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_CONTROL;
        end else if (in_byte == jsu_pkg::CHR_BSLASH) begin
          if (line_end) begin
            err      = 1'b1;
            err_code = jsu_pkg::ERR_ESCAPE;
          end else begin
            phase_next = jsu_pkg::PH_ESC;
          end
        end else begin
          has_bytes      = 1'b1;
          enc.bytes[0]   = in_byte;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (in_byte == jsu_pkg::CHR_U) begin
          if (line_end) begin
            err      = 1'b1;
            err_code = jsu_pkg::ERR_HEX;
          end else begin
            acc_next   = 16'd0;
            phase_next = jsu_pkg::PH_HI0;
          end
        end else if (esc[8]) begin
          has_bytes    = 1'b1;
          enc.bytes[0] = esc[7:0];
          phase_next   = jsu_pkg::PH_STR;
        end else begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_ESCAPE;
        end
      end
      jsu_pkg::PH_HI0, jsu_pkg::PH_HI1, jsu_pkg::PH_HI2,
      jsu_pkg::PH_LO0, jsu_pkg::PH_LO1, jsu_pkg::PH_LO2: begin
        if (dig[4] || line_end) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_HEX;
        end else begin
          acc_next   = acc_shift;
          phase_next = jsu_pkg::phase_t'(phase + 4'd1);
        end
      end
      jsu_pkg::PH_HI3: begin
        if (dig[4]) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_HEX;
        end else begin
          acc_next = acc_shift;
          if (acc_shift >= jsu_pkg::HI_SUR_MIN && acc_shift <= jsu_pkg::HI_SUR_MAX) begin
            if (line_end) begin
              err      = 1'b1;
              err_code = jsu_pkg::ERR_SURROGATE;
            end else begin
              hs_next    = acc_shift[9:0];
              phase_next = jsu_pkg::PH_SBS;
            end
          end else if (acc_shift >= jsu_pkg::LO_SUR_MIN
                       && acc_shift <= jsu_pkg::LO_SUR_MAX) begin
            err      = 1'b1;
            err_code = jsu_pkg::ERR_SURROGATE;
          end else begin
            has_bytes  = 1'b1;
            enc        = jsu_pkg::utf8_encode({5'd0, acc_shift});
            phase_next = jsu_pkg::PH_STR;
          end
        end
      end
      jsu_pkg::PH_LO3: begin
        if (dig[4]) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_HEX;
        end else begin
          acc_next = acc_shift;
          if (acc_shift < jsu_pkg::LO_SUR_MIN || acc_shift > jsu_pkg::LO_SUR_MAX) begin
            err      = 1'b1;
            err_code = jsu_pkg::ERR_SURROGATE;
          end else begin
            has_bytes  = 1'b1;
            enc        = jsu_pkg::utf8_encode({({1'b0, hs} + jsu_pkg::SUPP_PLANE),
                                               acc_shift[9:0]});
            phase_next = jsu_pkg::PH_STR;
          end
        end
      end
      jsu_pkg::PH_SBS: begin
        if (in_byte != jsu_pkg::CHR_BSLASH || line_end) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_SURROGATE;
        end else begin
          phase_next = jsu_pkg::PH_SU;
        end
      end
      jsu_pkg::PH_SU: begin
        if (in_byte != jsu_pkg::CHR_U) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_SURROGATE;
        end else if (line_end) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_HEX;
        end else begin
          acc_next   = 16'd0;
          phase_next = jsu_pkg::PH_LO0;
        end
      end
      default: begin
        if (in_byte != jsu_pkg::CHR_QUOTE) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_NO_QUOTE;
        end else if (line_end) begin
          err      = 1'b1;
          err_code = jsu_pkg::ERR_END;
        end else begin
          acc_next   = 16'd0;
          hs_next    = 10'd0;
          utf_next   = '0;
          phase_next = jsu_pkg::PH_STR;
        end
      end
    endcase

    // drop decoded bytes on a premature line end
    if (has_bytes && line_end) begin
      has_bytes = 1'b0;
      err       = 1'b1;
      err_code  = jsu_pkg::ERR_END;
    end

    if (err || closed) begin
      phase_next = jsu_pkg::PH_IDLE;
      acc_next   = 16'd0;
      hs_next    = 10'd0;
      utf_next   = '0;
    end else if (has_bytes) begin
      for (int i = 0; i < 4; i++) begin
        if (2'(i) <= enc.last_idx) begin
          utf_next = jsu_pkg::utf8_step(utf_next, enc.bytes[i]);
        end
      end
    end
  end

  always_comb begin
    has_result = err || closed || has_bytes;
    grp        = '0;
    if (err) begin
      grp.kind = jsu_pkg::KIND_ERROR;
      grp.code = err_code;
    end else if (closed) begin
      grp.kind = jsu_pkg::KIND_CLOSED;
    end else begin
      grp.kind     = jsu_pkg::KIND_BYTE;
      grp.bytes    = enc.bytes;
      grp.last_idx = enc.last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_IDLE;
      acc   <= 16'd0;
      hs    <= 10'd0;
      utf   <= '0;
    end else if (advance) begin
      phase <= phase_next;
      acc   <= acc_next;
      hs    <= hs_next;
      utf   <= utf_next;
    end
  end

  a_err_to_idle: assert property (@(posedge clk) disable iff (rst)
    advance && has_result && grp.kind == jsu_pkg::KIND_ERROR |=> phase == jsu_pkg::PH_IDLE)
    else $error("decoder not idle after error");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == jsu_pkg::PH_IDLE |-> utf.pending == 2'd0 && !utf.bad)
    else $error("validator state left over while idle");
  a_byte_no_code: assert property (@(posedge clk) disable iff (rst)
    has_result && grp.kind != jsu_pkg::KIND_BYTE |-> grp.last_idx == 2'd0)
    else $error("status result spans several beats");

endmodule

/* hdl/jsu_serial.sv */
// ----------------------------------------------------------------------------
// jsu_serial
// Result register holding one decoded group; sends its results one beat at
// a time and frees itself on the last beat.
// ----------------------------------------------------------------------------
module jsu_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  jsu_pkg::grp_t grp_in,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic [2:0]    error_code,
  output logic          last
);

  jsu_pkg::grp_t grp;
  logic [1:0]    idx;
  logic          valid;
  logic          fire;

  assign out_valid  = valid;
  assign out_byte   = grp.bytes[idx];
  assign kind       = grp.kind;
  assign error_code = grp.code;
  assign last       = (idx == grp.last_idx);
  assign fire       = valid && out_ready;
  assign free       = !valid || (fire && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (fire) begin
      if (last) begin
        valid <= 1'b0;
        idx   <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("group loaded over pending results");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> idx <= grp.last_idx)
    else $error("beat index past end of group");
  a_code_kind: assert property (@(posedge clk) disable iff (rst)
    valid && kind != jsu_pkg::KIND_ERROR |-> error_code == jsu_pkg::ERR_NONE)
    else $error("error code on non-error result");

endmodule

/* hdl/json_string_unescape_unit.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_unit
// Decodes a JSON string literal one raw byte per beat into UTF-8 bytes,
// a close marker or an error code.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, decoded
// combinationally and loaded into the result register, which presents it.
// Throughput: one input byte per cycle while each byte yields at most one
// result and out_ready holds high; a byte that yields several results (escape
// up to 4 bytes) holds the input side until the single result register drains.
// Reset: synchronous; clears the decoder state and the input and result valid
// flags, and leaves the block waiting for an opening quote.
module json_string_unescape_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [2:0] error_code,
  output logic       last
);

  logic          s1_valid;
  logic [7:0]    s1_byte;
  logic          s1_end;
  logic          advance;
  logic          ser_free;
  logic          has_result;
  jsu_pkg::grp_t grp;

  assign advance  = s1_valid && ser_free;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= in_byte;
      s1_end  <= line_end;
    end
  end

  jsu_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (s1_byte),
    .line_end   (s1_end),
    .advance    (advance),
    .has_result (has_result),
    .grp        (grp)
  );

  jsu_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && has_result),
    .grp_in     (grp),
    .free       (ser_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

endmodule

/* bench/json_string_unescape_unit_tb.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_unit_tb
// Feeds raw JSON string lines into the unescaper, one byte per beat, and
// checks every decoded byte, close marker and error against a cycle-free
// software decoder kept in step with the accepted input beats.
// ----------------------------------------------------------------------------
module json_string_unescape_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_BEATS = 20;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } beat_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       line_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  beat_t   expected_beats[$];
  beat_t   step_beats[$];
  byte_q_t line_buf;

  jsu_pkg::phase_t ph;
  logic [15:0]     hex_acc;
  logic [9:0]      hi_bits;
  logic [1:0]      u8_due;
  logic [1:0]      u8_lim;
  logic            u8_bad;

  int mismatches  = 0;
  int beats_sent  = 0;
  int cycle_count = 0;
  int rx_hold_left = 0;
  bit tx_idle_on  = 0;
  bit rx_idle_on  = 0;

  json_string_unescape_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .line_end   (line_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .kind       (kind),
    .error_code (error_code),
    .last       (last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Decoder model

  function automatic void reset_decoder();
    ph      = jsu_pkg::PH_IDLE;
    hex_acc = '0;
    hi_bits = '0;
    u8_due  = '0;
    u8_lim  = jsu_pkg::LIM_NONE;
    u8_bad  = 1'b0;
  endfunction

  function automatic void push_beat(logic [7:0] d, logic [1:0] k, logic [2:0] c);
    beat_t bt;
    bt = '{data: d, kind: k, code: c, last: 1'b0};
    step_beats.insert(step_beats.size(), bt);
  endfunction

  function automatic void raise_error(logic [2:0] c);
    push_beat(8'h00, jsu_pkg::KIND_ERROR, c);
    reset_decoder();
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return 5'd16;
  endfunction

  function automatic logic [8:0] escape_target(logic [7:0] c);
    case (c)
      "\"", "\\", "/": return {1'b1, c};
      "b":             return 9'h108;
      "f":             return 9'h10C;
      "n":             return 9'h10A;
      "r":             return 9'h10D;
      "t":             return 9'h109;
      default:         return 9'h000;
    endcase
  endfunction

  function automatic byte_q_t to_utf8(logic [20:0] cp);
    byte_q_t q;
    if (cp < 21'h80) begin
      q.insert(q.size(), cp[7:0]);
    end else if (cp < 21'h800) begin
      q.insert(q.size(), {3'b110, cp[10:6]});
      q.insert(q.size(), {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      q.insert(q.size(), {4'b1110, cp[15:12]});
      q.insert(q.size(), {2'b10, cp[11:6]});
      q.insert(q.size(), {2'b10, cp[5:0]});
    end else begin
      q.insert(q.size(), {5'b11110, cp[20:18]});
      q.insert(q.size(), {2'b10, cp[17:12]});
      q.insert(q.size(), {2'b10, cp[11:6]});
      q.insert(q.size(), {2'b10, cp[5:0]});
    end
    return q;
  endfunction

  function automatic void track_utf8(logic [7:0] b);
    logic [7:0] bound;
    logic       ok;
    bound = (u8_due == 2'd2) ? 8'hA0 : 8'h90;
    ok = (b[7:6] == 2'b10);
    if (u8_due == 2'd0) begin
      if (b >= 8'hC2 && b <= 8'hDF) begin
        u8_due = 2'd1;
        u8_lim = jsu_pkg::LIM_NONE;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        u8_due = 2'd2;
        u8_lim = (b == 8'hE0) ? jsu_pkg::LIM_MIN
               : (b == 8'hED) ? jsu_pkg::LIM_MAX : jsu_pkg::LIM_NONE;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        u8_due = 2'd3;
        u8_lim = (b == 8'hF0) ? jsu_pkg::LIM_MIN
               : (b == 8'hF4) ? jsu_pkg::LIM_MAX : jsu_pkg::LIM_NONE;
      end else if (b[7]) begin
        u8_bad = 1'b1;
      end
    end else begin
      if (u8_lim == jsu_pkg::LIM_MIN && b < bound) ok = 1'b0;
      if (u8_lim == jsu_pkg::LIM_MAX && b >= bound) ok = 1'b0;
      if (ok) begin
        u8_due = u8_due - 2'd1;
      end else begin
        u8_bad = 1'b1;
        u8_due = 2'd0;
      end
      u8_lim = jsu_pkg::LIM_NONE;
    end
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic le);
    byte_q_t    plain;
    logic [8:0] esc;
    logic [4:0] d;
    logic       low;
    logic [1:0] idx;
    step_beats.delete();
    case (ph)
      jsu_pkg::PH_STR: begin
        if (b == jsu_pkg::CHR_QUOTE) begin
          if (u8_bad || u8_due != 2'd0) begin
            raise_error(jsu_pkg::ERR_UTF8);
          end else begin
            push_beat(8'h00, jsu_pkg::KIND_CLOSED, jsu_pkg::ERR_NONE);
            reset_decoder();
          end
        end else if (b < jsu_pkg::CTRL_LIMIT) begin
          raise_error(jsu_pkg::ERR_CONTROL);
        end else if (b == jsu_pkg::CHR_BSLASH) begin
          if (le) raise_error(jsu_pkg::ERR_ESCAPE);
          else ph = jsu_pkg::PH_ESC;
        end else begin
          plain.insert(plain.size(), b);
        end
      end
      jsu_pkg::PH_ESC: begin
        esc = escape_target(b);
        if (b == jsu_pkg::CHR_U) begin
          if (le) begin
            raise_error(jsu_pkg::ERR_HEX);
          end else begin
            hex_acc = '0;
            ph = jsu_pkg::PH_HI0;
          end
        end else if (esc[8]) begin
          plain.insert(plain.size(), esc[7:0]);
          ph = jsu_pkg::PH_STR;
        end else begin
          raise_error(jsu_pkg::ERR_ESCAPE);
        end
      end
      jsu_pkg::PH_HI0, jsu_pkg::PH_HI1, jsu_pkg::PH_HI2, jsu_pkg::PH_HI3,
      jsu_pkg::PH_LO0, jsu_pkg::PH_LO1, jsu_pkg::PH_LO2, jsu_pkg::PH_LO3: begin
        low = (ph >= jsu_pkg::PH_LO0);
        idx = low ? 2'(ph - jsu_pkg::PH_LO0) : 2'(ph - jsu_pkg::PH_HI0);
        d = hex_digit(b);
        if (d[4]) begin
          raise_error(jsu_pkg::ERR_HEX);
        end else begin
          hex_acc = {hex_acc[11:0], d[3:0]};
          if (idx != 2'd3) begin
            if (le) raise_error(jsu_pkg::ERR_HEX);
            else ph = jsu_pkg::phase_t'(ph + 4'd1);
          end else if (!low) begin
            if (hex_acc >= jsu_pkg::HI_SUR_MIN && hex_acc <= jsu_pkg::HI_SUR_MAX) begin
              if (le) begin
                raise_error(jsu_pkg::ERR_SURROGATE);
              end else begin
                hi_bits = hex_acc[9:0];
                ph = jsu_pkg::PH_SBS;
              end
            end else if (hex_acc >= jsu_pkg::LO_SUR_MIN
                         && hex_acc <= jsu_pkg::LO_SUR_MAX) begin
              raise_error(jsu_pkg::ERR_SURROGATE);
            end else begin
              plain = to_utf8(21'(hex_acc));
              ph = jsu_pkg::PH_STR;
            end
          end else if (hex_acc < jsu_pkg::LO_SUR_MIN || hex_acc > jsu_pkg::LO_SUR_MAX) begin
            raise_error(jsu_pkg::ERR_SURROGATE);
          end else begin
            plain = to_utf8(21'h10000 + 21'({hi_bits, hex_acc[9:0]}));
            ph = jsu_pkg::PH_STR;
          end
        end
      end
      jsu_pkg::PH_SBS: begin
        if (b != jsu_pkg::CHR_BSLASH || le) raise_error(jsu_pkg::ERR_SURROGATE);
        else ph = jsu_pkg::PH_SU;
      end
      jsu_pkg::PH_SU: begin
        if (b != jsu_pkg::CHR_U) begin
          raise_error(jsu_pkg::ERR_SURROGATE);
        end else if (le) begin
          raise_error(jsu_pkg::ERR_HEX);
        end else begin
          hex_acc = '0;
          ph = jsu_pkg::PH_LO0;
        end
      end
      default: begin
        if (b != jsu_pkg::CHR_QUOTE) begin
          raise_error(jsu_pkg::ERR_NO_QUOTE);
        end else if (le) begin
          raise_error(jsu_pkg::ERR_END);
        end else begin
          reset_decoder();
          ph = jsu_pkg::PH_STR;
        end
      end
    endcase
    if (plain.size() != 0) begin
      if (le) begin
        raise_error(jsu_pkg::ERR_END);
      end else begin
        foreach (plain[i]) begin
          push_beat(plain[i], jsu_pkg::KIND_BYTE, jsu_pkg::ERR_NONE);
          track_utf8(plain[i]);
        end
      end
    end
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
    foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
  endfunction

  // Result checking

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t ns: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected result, out_byte", out_byte, 8'h00);
      end else begin
        want = expected_beats.pop_front();
        if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
        if (kind !== want.kind) report_mismatch("kind", 8'(kind), 8'(want.kind));
        if (error_code !== want.code)
          report_mismatch("error_code", 8'(error_code), 8'(want.code));
        if (last !== want.last) report_mismatch("last", 8'(last), 8'(want.last));
      end
    end
  end

  // Receiver: random stalls plus a long hold-off on request

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(0, 8);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Sender

  task automatic send_beat(logic [7:0] b, logic le);
    int gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    line_end <= le;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(b, le);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.insert(line_buf.size(), s[i]);
  endtask

  task automatic add_raw(logic [7:0] b);
    line_buf.insert(line_buf.size(), b);
  endtask

  task automatic add_seq(logic [31:0] seq, int count);
    for (int k = 0; k < count; k++) add_raw(seq[31 - 8 * k -: 8]);
  endtask

  task automatic add_utf8(logic [20:0] cp);
    byte_q_t q;
    q = to_utf8(cp);
    foreach (q[i]) add_raw(q[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
  endfunction

  task automatic add_hex_escape(logic [15:0] v);
    add_text("\\u");
    for (int k = 3; k >= 0; k--) add_raw(hex_char(v[4 * k +: 4]));
  endtask

  task automatic send_line(logic end_flag);
    foreach (line_buf[i]) send_beat(line_buf[i], end_flag && i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Tests

  task automatic test_plain_text();
    add_text("\" A~");
    add_raw(8'h7F);
    add_text("\"");
    send_line(1'b1);
    add_text("\"\"");
    send_line(1'b0);
  endtask

  task automatic test_framing_errors();
    add_raw(8'h00);
    add_raw(8'hFF);
    add_text("x");
    send_line(1'b0);
    add_text("\"");
    send_line(1'b1);
    add_text("\"ab");
    send_line(1'b1);
    add_text("\"a");
    add_raw(8'h1F);
    add_text("\"");
    add_raw(8'h00);
    send_line(1'b0);
  endtask

  task automatic test_short_escapes();
    add_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
    send_line(1'b0);
    add_text("\"\\x");
    send_line(1'b0);
    add_text("\"\\");
    send_line(1'b1);
    add_text("\"\\n");
    send_line(1'b1);
  endtask

  task automatic test_unicode_escapes();
    add_text("\"\\u0000\\u007F\\u0080\\u07FF\\u0800\\uFFFF");
    add_text("\\uD800\\uDC00\\uDBFF\\uDFFF\"");
    send_line(1'b1);
    add_text("\"\\u");
    send_line(1'b1);
    add_text("\"\\u12");
    send_line(1'b1);
    add_text("\"\\u12g");
    send_line(1'b0);
    add_text("\"\\u0041");
    send_line(1'b1);
  endtask

  task automatic test_surrogate_errors();
    add_text("\"\\uD83D");
    send_line(1'b1);
    add_text("\"\\uD83Dx\"\\uD83D\\x");
    send_line(1'b0);
    add_text("\"\\uD83D\\");
    send_line(1'b1);
    add_text("\"\\uD83D\\u");
    send_line(1'b1);
    add_text("\"\\uDC00\"\\uD83D\\u0041\"\\uD83D\\uZ");
    send_line(1'b0);
    add_text("\"\\uD83D\\uDC0");
    send_line(1'b1);
  endtask

  task automatic test_raw_utf8();
    add_text("\"");
    add_seq(32'hC280_DFBF, 4);
    add_seq(32'hE0A080_00, 3);
    add_seq(32'hED9FBF_00, 3);
    add_seq(32'hF0908080, 4);
    add_seq(32'hF48FBFBF, 4);
    add_text("\"");
    send_line(1'b1);
    add_text("\"");
    add_seq(32'hC0800000, 2);
    add_text("\"\"");
    add_seq(32'hF5000000, 1);
    add_text("\"\"");
    add_seq(32'hE09F8000, 3);
    add_text("\"\"");
    add_seq(32'hEDA08000, 3);
    add_text("\"\"");
    add_seq(32'hF4908080, 4);
    add_text("\"\"");
    add_seq(32'hC2410000, 2);
    add_text("\"\"");
    add_seq(32'hC2000000, 1);
    add_text("\"\"");
    add_seq(32'h80000000, 1);
    add_text("\"");
    send_line(1'b1);
  endtask

  task automatic test_backpressure();
    rx_hold_left = 120;
    add_text("\"");
    add_text("\\uD83D\\uDE00\\u20AC\\u20AC");
    add_text("\"");
    send_line(1'b1);
    wait_drained();
  endtask

  task automatic build_random_line(output logic end_flag);
    int          tokens;
    int          cut;
    logic [7:0]  c;
    logic [15:0] v;
    string       escs;
    escs = "\"\\/bfnrt";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) add_raw(8'($urandom));
      end_flag = $urandom_range(0, 1);
      return;
    end
    add_text("\"");
    tokens = $urandom_range(0, 8);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          c = 8'($urandom_range(32, 126));
          if (c == jsu_pkg::CHR_QUOTE || c == jsu_pkg::CHR_BSLASH) c = "_";
          add_raw(c);
        end
        2: begin
          case ($urandom_range(0, 2))
            0: add_utf8(21'($urandom_range(16'h80, 16'h7FF)));
            1: begin
              v = 16'($urandom_range(16'h800, 16'hFFFF));
              if (v >= jsu_pkg::HI_SUR_MIN && v <= jsu_pkg::LO_SUR_MAX) v = v ^ 16'h4000;
              add_utf8(21'(v));
            end
            default: add_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)));
          endcase
        end
        3: begin
          add_text("\\");
          add_raw(escs[$urandom_range(0, escs.len() - 1)]);
        end
        4, 5: add_hex_escape(16'($urandom));
        6: begin
          add_hex_escape(jsu_pkg::HI_SUR_MIN | 16'($urandom_range(0, 1023)));
          add_hex_escape(jsu_pkg::LO_SUR_MIN | 16'($urandom_range(0, 1023)));
        end
        7: begin
          v = 16'($urandom);
          if (v >= jsu_pkg::HI_SUR_MIN && v <= jsu_pkg::LO_SUR_MAX) v = v ^ 16'h4000;
          add_hex_escape(v);
        end
        8: add_raw(8'($urandom_range(8'h80, 8'hFF)));
        default: add_raw(8'($urandom));
      endcase
    end
    add_text("\"");
    end_flag = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, line_buf.size() - 1);
      if ($urandom_range(0, 1)) begin
        line_buf[cut] = 8'($urandom);
      end else begin
        while (line_buf.size() > cut + 1) void'(line_buf.pop_back());
        end_flag = 1'b1;
      end
    end
  endtask

  task automatic test_random_lines();
    int   first_beat;
    logic end_flag;
    first_beat = beats_sent;
    tx_idle_on = 0;
    rx_idle_on = 0;
    while (beats_sent < first_beat + RANDOM_BEATS) begin
      build_random_line(end_flag);
      send_line(end_flag);
    end
  endtask

  initial begin
    in_valid = 1'b0;
    in_byte  = 8'h00;
    line_end = 1'b0;
    rst      = 1'b1;
    reset_decoder();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_plain_text();
    tx_idle_on = 1;
    rx_idle_on = 1;
    test_framing_errors();
    test_short_escapes();
    test_unicode_escapes();
    test_surrogate_errors();
    test_raw_utf8();
    test_backpressure();
    test_random_lines();
    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
